// File: hw/rtl/text_console_writer_unit_macros.svh
// Assertion helpers used by the console writer back end (tcw_back).
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// Checked only while out of reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int POS_W  = 11;
	localparam int CELL_W = 16;

	localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [7:0] CHAR_RETURN    = 8'd13;
	localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
	localparam logic [7:0] CHAR_TAB       = 8'd9;
	localparam logic [7:0] CHAR_BLANK     = 8'h20;
	localparam logic [7:0] ATTR_RESET     = 8'h0F;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	typedef enum logic [2:0] {
		OP_CHAR,
		OP_NEWLINE,
		OP_RETURN,
		OP_BACKSPACE,
		OP_TAB,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_SCROLL,
		ST_BLANK
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  ch;
		logic [10:0] idx;
	} item_t;

endpackage
`default_nettype wire

// File: hw/rtl/tcw_if.sv
`default_nettype none
interface tcw_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  char_code;
	logic [10:0] cell_index;

	modport source (output valid, output command, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input command, input char_code, input cell_index,
		output ready);
endinterface

interface tcw_rsp_if;
	logic        valid;
	logic        ready;
	logic [10:0] cursor_position;
	logic [15:0] cell_value;

	modport source (output valid, output cursor_position, output cell_value, input ready);
	modport sink (input valid, input cursor_position, input cell_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tcw_front.sv
`default_nettype none
module tcw_front #(
	parameter int SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tcw_cmd_if.sink      cmd,
	output tcw_pkg::item_t head,
	output logic         head_valid,
	input  wire logic    pop
);
	import tcw_pkg::*;

	localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	always_comb begin
		cls.ch  = cmd.char_code;
		cls.idx = cmd.cell_index;
		unique case (cmd.command)
			CMD_PUT: begin
				unique case (cmd.char_code)
					CHAR_NEWLINE:   cls.op = OP_NEWLINE;
					CHAR_RETURN:    cls.op = OP_RETURN;
					CHAR_BACKSPACE: cls.op = OP_BACKSPACE;
					CHAR_TAB:       cls.op = OP_TAB;
					default:        cls.op = OP_CHAR;
				endcase
			end
			CMD_CLEAR: cls.op = OP_CLEAR;
			// A read beyond the screen returns zero, just like an unused command.
			CMD_READ:  cls.op = (int'(cmd.cell_index) < CELLS) ? OP_READ : OP_NOP;
			default:   cls.op = OP_NOP;
		endcase
	end

	assign cmd.ready  = (cnt_q != 2'd2);
	assign push       = cmd.valid && cmd.ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/tcw_back.sv
`default_nettype none
`include "text_console_writer_unit_macros.svh"
module tcw_back #(
	parameter int SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tcw_pkg::item_t head,
	input  wire logic           head_valid,
	output logic                pop,
	input  wire logic           attr_we,
	input  wire logic [7:0]     attr_data,
	tcw_rsp_if.source           rsp
);
	import tcw_pkg::*;

	localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int ROW_W = $clog2(SCREEN_ROWS);
	localparam int COL_W = $clog2(SCREEN_COLUMNS);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_SRC  = AW'(CELLS - SCREEN_COLUMNS);
	localparam logic [AW-1:0] ROW_SPAN  = AW'(SCREEN_COLUMNS);

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;

	state_t            state_q, state_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [AW-1:0]     cnt_q, cnt_d;
	logic [7:0]        attr_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  pos_q;
	logic [CELL_W-1:0] cellv_q;

	logic              take;
	logic              out_free;
	logic [COL_W:0]    col_inc;
	logic [COL_W:0]    col_tab;
	logic              next_line;
	logic              scroll;
	logic [AW-1:0]     cur_addr;
	logic [CELL_W-1:0] blank;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic [AW-1:0]     raddr;
	logic              out_load;
	logic [CELL_W-1:0] cell_d;

	assign out_free = !out_valid_q || rsp.ready;
	assign take     = (state_q == ST_IDLE) && head_valid && out_free;
	assign col_inc  = {1'b0, col_q} + (COL_W + 1)'(1);
	assign col_tab  = ({1'b0, col_q} + (COL_W + 1)'(4)) & ~(COL_W + 1)'(3);
	assign cur_addr = AW'(int'(row_q) * SCREEN_COLUMNS + int'(col_q));
	assign blank    = {attr_q, CHAR_BLANK};

	always_comb begin
		unique case (head.op)
			OP_CHAR:    next_line = (int'(col_inc) >= SCREEN_COLUMNS);
			OP_NEWLINE: next_line = 1'b1;
			OP_TAB:     next_line = (int'(col_tab) >= SCREEN_COLUMNS);
			default:    next_line = 1'b0;
		endcase
		scroll = next_line && (int'(row_q) + 1 >= SCREEN_ROWS);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (cnt_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (take) begin
					if (head.op == OP_CLEAR) begin
						state_d = ST_BLANK;
					end else if (head.op == OP_READ) begin
						state_d = ST_RD;
					end else if (scroll) begin
						state_d = ST_SCROLL;
					end
				end
			end
			ST_RD: state_d = ST_IDLE;
			ST_SCROLL: begin
				if (cnt_q == LAST_SRC) begin
					state_d = ST_BLANK;
				end
			end
			ST_BLANK: begin
				if (cnt_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Datapath and outputs.
	always_comb begin
		row_d    = row_q;
		col_d    = col_q;
		cnt_d    = cnt_q;
		we       = 1'b0;
		waddr    = cur_addr;
		wdata    = blank;
		raddr    = '0;
		pop      = 1'b0;
		out_load = 1'b0;
		cell_d   = '0;
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = {ATTR_RESET, CHAR_BLANK};
				cnt_d = (cnt_q == LAST_CELL) ? '0 : cnt_q + AW'(1);
			end
			ST_IDLE: begin
				if (take) begin
					pop = 1'b1;
					unique case (head.op)
						OP_CHAR: begin
							we    = 1'b1;
							wdata = {attr_q, head.ch};
							col_d = col_inc[COL_W-1:0];
						end
						OP_NEWLINE, OP_RETURN: col_d = '0;
						OP_BACKSPACE: begin
							if (col_q != '0) begin
								col_d = col_q - COL_W'(1);
								we    = 1'b1;
								waddr = cur_addr - AW'(1);
							end
						end
						OP_TAB: col_d = col_tab[COL_W-1:0];
						OP_CLEAR: begin
							row_d = '0;
							col_d = '0;
							cnt_d = '0;
						end
						OP_READ: raddr = AW'(head.idx);
						OP_NOP: ;
						default: ;
					endcase
					if (next_line) begin
						col_d = '0;
						// Past the last row the cursor stays on it and the screen moves up.
						if (scroll) begin
							cnt_d = '0;
						end else begin
							row_d = row_q + ROW_W'(1);
						end
					end
					out_load = (head.op != OP_CLEAR) && (head.op != OP_READ) && !scroll;
				end
			end
			ST_RD: begin
				out_load = 1'b1;
				cell_d   = rdata_q;
			end
			ST_SCROLL: begin
				// Each cell is read one row down and written back from the registered read data in the following cycle.
				if (cnt_q != LAST_SRC) begin
					raddr = cnt_q + ROW_SPAN;
					cnt_d = cnt_q + AW'(1);
				end
				if (cnt_q != '0) begin
					we    = 1'b1;
					waddr = cnt_q - AW'(1);
					wdata = rdata_q;
				end
			end
			ST_BLANK: begin
				we    = 1'b1;
				waddr = cnt_q;
				if (cnt_q == LAST_CELL) begin
					cnt_d    = '0;
					out_load = 1'b1;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_q   <= POS_W'(int'(row_d) * SCREEN_COLUMNS + int'(col_d));
			cellv_q <= cell_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			attr_q      <= ATTR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			cnt_q   <= cnt_d;
			if (attr_we) begin
				attr_q <= attr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.cursor_position = pos_q;
	assign rsp.cell_value      = cellv_q;

	`TCW_ASSERT(a_row_range, clk, arst_n, int'(row_q) < SCREEN_ROWS, "cursor row out of range")
	`TCW_ASSERT(a_col_range, clk, arst_n, int'(col_q) < SCREEN_COLUMNS, "cursor column out of range")
	`TCW_ASSERT(a_pop_idle, clk, arst_n, pop |-> (state_q == ST_IDLE && head_valid), "pop outside idle")
	`TCW_ASSERT(a_rd_free, clk, arst_n, (state_q == ST_RD) |-> !out_valid_q, "result register busy on read")
	`TCW_ASSERT_ALWAYS(a_init_quiet, clk, (state_q == ST_INIT) |-> !out_valid_q, "result during clearing pass")

endmodule
`default_nettype wire

// File: hw/rtl/text_console_writer_unit.sv
`default_nettype none
// Text console writer. Commands enter on cmd and each produces one beat on rsp carrying the
// cursor position and, for a read, the cell. After reset the screen memory is swept to blank
// cells, one cell a cycle, before the first command runs. A printable character, newline,
// return, backspace or tab that does not scroll is executed in the idle state, while a read
// also passes through the ST_RD state because the screen memory has a registered read port.
// A clear blanks every cell, and a put that moves past the last row copies each row up one
// and blanks the last row, both through the single write port of the screen memory. A
// two-beat queue after the command decoder keeps accepting commands, until it is full, while
// the executor is busy or the result waits to be taken.
module text_console_writer_unit #(
	parameter int SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	tcw_cmd_if.sink         cmd,
	tcw_rsp_if.source       rsp,
	input  wire logic       attr_we,
	input  wire logic [7:0] attr_data
);
	import tcw_pkg::*;

	item_t head;
	logic  head_valid;
	logic  pop;

	tcw_front #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop)
	);

	tcw_back #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.attr_we   (attr_we),
		.attr_data (attr_data),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
